@@ rtl/maf_pkg.sv @@
// Package for the moving average filter: default sizes and the width of the
// window-size configuration port. Used by the top level only.
`timescale 1ns / 1ps
package maf_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_BITS        = 9;

endpackage

@@ rtl/maf_div.sv @@
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on maf_pkg only through the parameters handed down by the top level.
`timescale 1ns / 1ps
module maf_div #(
	parameter int NUM_BITS = 24,
	parameter int DEN_BITS = 9,
	parameter int OUT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [NUM_BITS-1:0] num,
	input  logic        [DEN_BITS-1:0] den,
	output logic                       busy,
	output logic signed [OUT_BITS-1:0] quot
);

	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic                busy_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [NUM_BITS-1:0] acc_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic                neg_q;

	logic [NUM_BITS-1:0] num_mag;
	logic [DEN_BITS:0]   trial;
	logic                q_bit;
	logic [DEN_BITS:0]   trial_sub;
	logic [OUT_BITS-1:0] quot_mag;

	assign num_mag   = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
	assign trial     = {rem_q, acc_q[NUM_BITS-1]};
	assign q_bit     = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};
	assign quot_mag  = acc_q[OUT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(NUM_BITS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift the dividend out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_BITS-1];
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_BITS-2:0], q_bit};
			rem_q <= q_bit ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? OUT_BITS'(-quot_mag) : OUT_BITS'(quot_mag);

endmodule

@@ rtl/moving_average_filter.sv @@
// Each item taken passes the states READ, UPD and DIV; in DIV the bit-serial
// divider produces one quotient bit a cycle. A new item is taken only after
// the result has been loaded into the output register, which waits on m_tready.
// Reset (asynchronous, active low) sets the window to 1 and empties the store;
// a window write empties it as well. No clearing pass is needed.
// Depends on maf_pkg and maf_div.
`timescale 1ns / 1ps
module moving_average_filter #(
	parameter int MAX_WINDOW  = maf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [maf_pkg::CFG_BITS-1:0]        cfg_data,   // window_size
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,    // sample
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata     // average
);

	localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
	localparam int ADDR_BITS  = $clog2(MAX_WINDOW);
	localparam int SUM_BITS   = SAMPLE_BITS + ADDR_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPD,
		ST_DIV
	} state_t;

	state_t                         state_q;
	logic [WIN_BITS-1:0]            window_q;
	logic [ADDR_BITS-1:0]           pos_q;
	logic                           wrapped_q;
	logic signed [SUM_BITS-1:0]     sum_q;
	logic signed [SAMPLE_BITS-1:0]  sample_q;
	logic signed [SAMPLE_BITS-1:0]  rd_data_q;
	logic signed [SAMPLE_BITS-1:0]  store_q [MAX_WINDOW];
	logic                           m_tvalid_q;
	logic [TDATA_BITS-1:0]          m_tdata_q;

	logic [WIN_BITS-1:0]            cfg_win;
	logic [WIN_BITS-1:0]            pos_inc;
	logic                           pos_wrap;
	logic signed [SAMPLE_BITS-1:0]  old_sample;
	logic signed [SUM_BITS-1:0]     sum_next;
	logic                           div_start;
	logic                           div_busy;
	logic signed [SAMPLE_BITS-1:0]  div_quot;
	logic                           in_fire;
	logic                           out_load;

	// Clamp the written window to 1..MAX_WINDOW
	always_comb begin
		cfg_win = WIN_BITS'(MAX_WINDOW);
		if (cfg_data == '0) begin
			cfg_win = WIN_BITS'(1);
		end else if (int'(cfg_data) <= MAX_WINDOW) begin
			cfg_win = WIN_BITS'(cfg_data);
		end
	end

	assign in_fire    = s_tvalid && s_tready;
	assign pos_inc    = WIN_BITS'(pos_q) + WIN_BITS'(1);
	assign pos_wrap   = (pos_inc >= window_q);
	// Entries are written in order from position zero, so before the first
	// wrap the entry under the pointer has not been written since clearing
	assign old_sample = wrapped_q ? rd_data_q : '0;
	assign sum_next   = sum_q + SUM_BITS'(sample_q) - SUM_BITS'(old_sample);
	assign div_start  = (state_q == ST_UPD);
	assign out_load   = (state_q == ST_DIV) && !div_busy && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_data_q <= store_q[pos_q];
		end
		if (state_q == ST_UPD) begin
			store_q[pos_q] <= sample_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= WIN_BITS'(1);
			pos_q      <= '0;
			wrapped_q  <= 1'b0;
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				window_q  <= cfg_win;
				pos_q     <= '0;
				wrapped_q <= 1'b0;
				sum_q     <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					sum_q <= sum_next;
					if (pos_wrap) begin
						pos_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						pos_q <= ADDR_BITS'(pos_inc);
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// Hold the quotient until the output register is free
					if (out_load) begin
						m_tdata_q  <= TDATA_BITS'(unsigned'(div_quot));
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	maf_div #(
		.NUM_BITS (SUM_BITS),
		.DEN_BITS (WIN_BITS),
		.OUT_BITS (SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_next),
		.den    (window_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/maf_chk.sv @@
// Port-level checker for the moving average filter, bound to the top level.
// Depends on moving_average_filter being compiled first.
`timescale 1ns / 1ps
module maf_chk #(
	parameter int TDATA_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [TDATA_BITS-1:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	// Count items taken whose result has not yet been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("item taken while the previous one is still at work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result shown without an item taken");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

endmodule

bind moving_average_filter maf_chk #(
	.TDATA_BITS (((SAMPLE_BITS + 7) / 8) * 8)
) u_maf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
